// ===== rtl/mves_pkg.sv =====
// ----------------------------------------------------------------------------
// mves_pkg
// Shared types, codes, tables and small helpers of the envelope synthesizer.
// ----------------------------------------------------------------------------
package mves_pkg;

  localparam int SAMPLE_RATE_DEF  = 44100;
  localparam int MUSIC_VOICES_DEF = 4;
  localparam int NUM_NOTES        = 37;
  localparam int NUM_INSTR        = 6;
  localparam int NUM_FX           = 7;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_NOTE = 2'd1;
  localparam logic [1:0] OP_FX   = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  localparam logic [1:0] STG_IDLE = 2'd0;
  localparam logic [1:0] STG_ATK  = 2'd1;
  localparam logic [1:0] STG_DEC  = 2'd2;
  localparam logic [1:0] STG_REL  = 2'd3;

  localparam logic [1:0] WV_RAMP     = 2'd0;
  localparam logic [1:0] WV_PULSE    = 2'd1;
  localparam logic [1:0] WV_TRIANGLE = 2'd2;
  localparam logic [1:0] WV_NOISE    = 2'd3;

  localparam logic [15:0] LFSR_SEED  = 16'hACE1;
  localparam logic [15:0] LFSR_TAP   = 16'hB400;
  localparam logic [16:0] GAIN_FULL  = 17'd65536;
  localparam logic [16:0] GAIN_DUCK  = 17'(12 << 12);
  localparam logic [16:0] GAIN_SLEW  = 17'd48;
  localparam logic [16:0] LVL_FULL   = 17'd65536;
  localparam logic [16:0] LVL_FLOOR  = 17'd64;
  localparam logic [15:0] RECIP_255  = 16'd32897;
  localparam logic [15:0] WIND_BASE  = 16'd32768;

  localparam logic [15:0] PITCH_DHZ [NUM_NOTES] = '{
    16'd550,  16'd583,  16'd617,  16'd654,  16'd693,  16'd734,  16'd778,  16'd824,
    16'd873,  16'd925,  16'd980,  16'd1038, 16'd1100, 16'd1165, 16'd1235, 16'd1308,
    16'd1386, 16'd1468, 16'd1556, 16'd1648, 16'd1746, 16'd1850, 16'd1960, 16'd2077,
    16'd2200, 16'd2331, 16'd2469, 16'd2616, 16'd2772, 16'd2937, 16'd3111, 16'd3296,
    16'd3492, 16'd3700, 16'd3920, 16'd4153, 16'd4400
  };

  localparam logic [15:0] FX_DHZ [NUM_FX] = '{
    16'd0, 16'd1960, 16'd1308, 16'd880, 16'd440, 16'd330, 16'd2616
  };

  localparam logic [2:0] FX_INSTR [NUM_FX] = '{
    3'd0, 3'd4, 3'd4, 3'd3, 3'd0, 3'd0, 3'd5
  };

  typedef logic [31:0] note_tbl_t [NUM_NOTES];
  typedef logic [31:0] fx_tbl_t [NUM_FX];

  typedef struct packed {
    logic [1:0]  wave;
    logic [7:0]  duty;
    logic [14:0] atk;
    logic [15:0] dec;
    logic [14:0] sus;
    logic [15:0] rel;
    logic [4:0]  vdepth;
    logic [5:0]  vrate;
    logic [7:0]  vol;
  } instr_t;

  typedef struct packed {
    logic [31:0] step;
    logic [16:0] level;
    logic [1:0]  stage;
    logic [2:0]  instr;
  } voice_ctl_t;

  typedef struct packed {
    logic [31:0] osc;
    logic [31:0] vib;
  } voice_phs_t;

  // Codes six and seven never get stored; they fold like a modulo six would.
  function automatic instr_t instr_rom(input logic [2:0] idx);
    instr_t r;
    case (idx)
      3'd1:    r = '{WV_PULSE, 8'd96,  15'd1800,  16'd65450, 15'd20000, 16'd65200,
                     5'd12, 6'd40, 8'd170};
      3'd2:    r = '{WV_TRIANGLE, 8'd128, 15'd240, 16'd65530, 15'd30000, 16'd65400,
                     5'd5,  6'd18, 8'd130};
      3'd3:    r = '{WV_NOISE, 8'd128, 15'd20000, 16'd64200, 15'd0,     16'd64000,
                     5'd0,  6'd0,  8'd210};
      3'd4:    r = '{WV_PULSE, 8'd64,  15'd6000,  16'd65200, 15'd8000,  16'd65000,
                     5'd20, 6'd55, 8'd150};
      3'd5:    r = '{WV_TRIANGLE, 8'd128, 15'd4000, 16'd65350, 15'd12000, 16'd65250,
                     5'd8,  6'd28, 8'd160};
      3'd7:    r = '{WV_PULSE, 8'd96,  15'd1800,  16'd65450, 15'd20000, 16'd65200,
                     5'd12, 6'd40, 8'd170};
      default: r = '{WV_RAMP, 8'd128, 15'd900,    16'd65500, 15'd26000, 16'd65100,
                     5'd0,  6'd0,  8'd200};
    endcase
    return r;
  endfunction

  function automatic logic [15:0] lfsr_step(input logic [15:0] l);
    return (l >> 1) ^ (l[0] ? LFSR_TAP : 16'h0000);
  endfunction

  // Noise sample is the new register value offset by half scale.
  function automatic logic signed [15:0] noise_val(input logic [15:0] l);
    return $signed({~l[15], l[14:0]});
  endfunction

  function automatic logic signed [15:0] tri_val(input logic [31:0] ph);
    logic [16:0] t;
    logic [16:0] r;
    t = ph[31:15];
    r = t[16] ? ~t : t;
    return $signed({~r[15], r[14:0]});
  endfunction

endpackage

// ===== rtl/mves_wave.sv =====
// ----------------------------------------------------------------------------
// mves_wave
// Oscillator waveform shaper: saw, square, triangle and LFSR noise.
// ----------------------------------------------------------------------------
module mves_wave import mves_pkg::*; (
  input  logic [1:0]         wave_i,
  input  logic [7:0]         duty_i,
  input  logic [31:0]        phase_i,
  input  logic [15:0]        lfsr_i,
  output logic signed [15:0] value_o,
  output logic [15:0]        lfsr_o
);

  logic signed [16:0] duty_amp;

  assign lfsr_o   = lfsr_step(lfsr_i);
  assign duty_amp = $signed({2'b00, duty_i, 7'b0});

  always_comb begin
    case (wave_i)
      WV_RAMP:     value_o = $signed({~phase_i[31], phase_i[30:16]});
      WV_TRIANGLE: value_o = tri_val(phase_i);
      WV_NOISE:    value_o = noise_val(lfsr_o);
      default: begin
        // The high part of the square is lowered so the mean stays near zero.
        if (phase_i[31:24] < duty_i) begin
          value_o = 16'(17'sd32767 - duty_amp);
        end else begin
          value_o = 16'(-duty_amp);
        end
      end
    endcase
  end

endmodule

// ===== rtl/multi_voice_envelope_synth.sv =====
// ----------------------------------------------------------------------------
// multi_voice_envelope_synth
// Multi-voice oscillator and envelope sound generator with a wind noise bed.
// ----------------------------------------------------------------------------
// A note-on or effect transfer is taken while idle and yields no sample. A tick
// transfer yields its sample after one shared datapath has stepped the voices
// in turn through a read, envelope, oscillator, wave with level multiply, volume
// multiply, divide and accumulate stage each, with gain stages after the music
// voices and wind stages after the effect voice; no new input is taken until the
// block is idle again. A sample that is not taken holds the block at its last
// stage. Voice state sits in two small memories with valid bits, so it reads as
// zero after reset without a clearing pass.
module multi_voice_envelope_synth import mves_pkg::*; #(
  parameter int SAMPLE_RATE  = SAMPLE_RATE_DEF,
  parameter int MUSIC_VOICES = MUSIC_VOICES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [1:0]         voice_select_i,
  input  logic [5:0]         note_index_i,
  input  logic [2:0]         instrument_select_i,
  input  logic [2:0]         effect_select_i,
  input  logic               duck_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_o
);

  localparam int NV = MUSIC_VOICES + 1;
  localparam int AW = $clog2(NV);
  localparam logic [AW-1:0] FxAddr   = AW'(MUSIC_VOICES);
  localparam logic [AW-1:0] LastMus  = AW'(MUSIC_VOICES - 1);
  localparam longint unsigned StepDen = longint'(SAMPLE_RATE) * 10;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_ENV  = 4'd2;
  localparam logic [3:0] ST_OSC  = 4'd3;
  localparam logic [3:0] ST_WAV  = 4'd4;
  localparam logic [3:0] ST_MUL  = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_ACC  = 4'd7;
  localparam logic [3:0] ST_GAIN = 4'd8;
  localparam logic [3:0] ST_GSC  = 4'd9;
  localparam logic [3:0] ST_WND  = 4'd10;
  localparam logic [3:0] ST_WMUL = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  function automatic note_tbl_t note_steps();
    note_tbl_t t;
    for (int i = 0; i < NUM_NOTES; i++) begin
      t[i] = 32'((64'(PITCH_DHZ[i]) << 32) / StepDen);
    end
    return t;
  endfunction

  function automatic fx_tbl_t fx_steps();
    fx_tbl_t t;
    for (int i = 0; i < NUM_FX; i++) begin
      t[i] = 32'((64'(FX_DHZ[i]) << 32) / StepDen);
    end
    return t;
  endfunction

  localparam note_tbl_t NoteStep = note_steps();
  localparam fx_tbl_t   FxStep   = fx_steps();

  // Voice memories and their valid bits.
  voice_ctl_t mem_ctl [NV];
  voice_phs_t mem_phs [NV];
  logic [NV-1:0] vld_ctl_q, vld_phs_q;
  voice_ctl_t rd_ctl_q;
  voice_phs_t rd_phs_q;
  logic rdv_ctl_q, rdv_phs_q;

  logic          ctl_we, phs_we;
  logic [AW-1:0] ctl_wa;
  voice_ctl_t    ctl_wd;
  voice_phs_t    phs_wd;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] v_q, v_d;
  logic [7:0]    tension_q;
  logic [15:0]   lfsr_q, lfsr_d;
  logic signed [16:0] wind_q, wind_d;
  logic [16:0]   gain_q, gain_d;
  logic signed [19:0] acc_q, acc_d;

  voice_ctl_t cur_ctl_q;
  voice_phs_t cur_phs_q;
  logic [32:0] prod_q;
  logic [16:0] lvl1_q;
  logic [1:0]  stg1_q;
  logic        use_prod_q;
  logic [31:0] osc_q;
  logic [16:0] lvl_q;
  logic        idle_q;
  logic signed [33:0] sprod_q;
  logic signed [25:0] y_q;
  logic [24:0] a_q;
  logic        neg_q;
  logic [15:0] qe_q;
  logic signed [37:0] gprod_q;
  logic signed [33:0] wprod_q;
  logic signed [15:0] sample_q;
  logic        out_valid_q;

  logic in_fire, out_fire, cfg_wr;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign prdata      = paddr[2] ? 32'd0 : {24'd0, tension_q};

  // ---------------- envelope stage ----------------
  voice_ctl_t ctl_rd;
  voice_phs_t phs_rd;
  instr_t     ins_rd, ins_cur;
  logic [17:0] atk_sum;
  logic [32:0] env_prod;
  logic [16:0] env_lvl1;
  logic [1:0]  env_stg1;
  logic        env_use;

  assign ctl_rd  = rdv_ctl_q ? rd_ctl_q : '0;
  assign phs_rd  = rdv_phs_q ? rd_phs_q : '0;
  assign ins_rd  = instr_rom(ctl_rd.instr);
  assign ins_cur = instr_rom(cur_ctl_q.instr);
  assign atk_sum = 18'(ctl_rd.level) + 18'(ins_rd.atk);

  always_comb begin
    env_lvl1 = ctl_rd.level;
    env_stg1 = ctl_rd.stage;
    env_use  = 1'b0;
    env_prod = 33'(ctl_rd.level) * 33'(ins_rd.rel);
    case (ctl_rd.stage)
      STG_ATK: begin
        if (atk_sum >= 18'(LVL_FULL)) begin
          env_lvl1 = LVL_FULL;
          env_stg1 = STG_DEC;
        end else begin
          env_lvl1 = atk_sum[16:0];
        end
      end
      STG_DEC: begin
        env_prod = 33'(ctl_rd.level) * 33'(ins_rd.dec);
        env_use  = ctl_rd.level > 17'(ins_rd.sus);
      end
      STG_REL: env_use = 1'b1;
      default: ;
    endcase
  end

  // ---------------- oscillator stage ----------------
  logic [16:0] nl;
  logic [1:0]  ns;
  logic        n_idle;
  logic [31:0] vib_n, inc, osc_n;
  logic signed [15:0] tv;
  logic signed [16:0] tvb;
  logic signed [8:0]  q1;
  logic signed [14:0] vm, vmb, q2;

  always_comb begin
    nl = lvl1_q;
    ns = stg1_q;
    if (use_prod_q) begin
      nl = prod_q[32:16];
      if (stg1_q == STG_DEC && nl < 17'(ins_cur.sus)) begin
        nl = 17'(ins_cur.sus);
      end
      if (stg1_q == STG_REL && nl < LVL_FLOOR) begin
        nl = 17'd0;
        ns = STG_IDLE;
      end
    end
  end

  assign n_idle = (ns == STG_IDLE) && (nl == 17'd0);
  assign vib_n  = cur_phs_q.vib + (32'(ins_cur.vrate) << 18);
  assign tv     = tri_val(vib_n);
  // Both vibrato divisions truncate toward zero, hence the bias on negatives.
  assign tvb    = 17'(tv) + ((tv < 0) ? 17'sd255 : 17'sd0);
  assign q1     = 9'(tvb >>> 8);
  assign vm     = q1 * $signed({1'b0, ins_cur.vdepth});
  assign vmb    = vm + ((vm < 0) ? 15'sd63 : 15'sd0);
  assign q2     = vmb >>> 6;
  assign inc    = (ins_cur.vdepth != 5'd0) ? cur_ctl_q.step + 32'(q2) : cur_ctl_q.step;
  assign osc_n  = cur_phs_q.osc + inc;

  // ---------------- wave and scaling stages ----------------
  logic signed [15:0] wv;
  logic [15:0] wave_lfsr;
  logic signed [33:0] sp;
  logic signed [17:0] sx;
  logic signed [26:0] yf;
  logic [24:0] a_n;
  logic [40:0] est;
  logic [23:0] q255;
  logic [15:0] qf;
  logic signed [16:0] sv;

  mves_wave u_wave (
    .wave_i  (ins_cur.wave),
    .duty_i  (ins_cur.duty),
    .phase_i (osc_q),
    .lfsr_i  (lfsr_q),
    .value_o (wv),
    .lfsr_o  (wave_lfsr)
  );

  assign sp   = wv * $signed({1'b0, lvl_q});
  assign sx   = $signed(sprod_q[33:16]);
  assign yf   = sx * $signed({1'b0, ins_cur.vol});
  assign a_n  = (y_q < 0) ? 25'(-y_q) : 25'(y_q);
  assign est  = 41'(a_n) * 41'(RECIP_255);
  // The reciprocal estimate is at most one above the true quotient.
  assign q255 = {qe_q, 8'b0} - 24'(qe_q);
  assign qf   = (25'(q255) > a_q) ? qe_q - 16'd1 : qe_q;
  assign sv   = neg_q ? -$signed({1'b0, qf}) : $signed({1'b0, qf});

  // ---------------- mix, wind and output ----------------
  logic signed [37:0] gp;
  logic signed [15:0] wn;
  logic [15:0] wl;
  logic signed [17:0] wdiff;
  logic [15:0] wfac;
  logic signed [33:0] wp;
  logic signed [22:0] tot;
  logic [16:0] want, gain_up, gain_dn;

  assign gp      = acc_q * $signed({1'b0, gain_q});
  assign wl      = lfsr_step(lfsr_q);
  assign wn      = noise_val(wl);
  assign wdiff   = 18'(wn) - 18'(wind_q);
  assign wfac    = WIND_BASE + {2'b00, tension_q, 6'b0};
  assign wp      = wind_q * $signed({1'b0, wfac});
  assign tot     = (23'(acc_q) + 23'(wprod_q >>> 19)) <<< 1;
  assign want    = duck_i ? GAIN_DUCK : GAIN_FULL;
  assign gain_up = gain_q + GAIN_SLEW;
  assign gain_dn = gain_q - GAIN_SLEW;

  always_comb begin
    state_d = state_q;
    v_d     = v_q;
    lfsr_d  = lfsr_q;
    wind_d  = wind_q;
    gain_d  = gain_q;
    acc_d   = acc_q;
    ctl_we  = 1'b0;
    phs_we  = 1'b0;
    ctl_wa  = v_q;
    ctl_wd  = '0;
    phs_wd  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (op_i)
            OP_TICK: begin
              if (gain_q < want) begin
                gain_d = (gain_up > want) ? want : gain_up;
              end else if (gain_q > want) begin
                gain_d = (gain_dn < want) ? want : gain_dn;
              end
              acc_d   = '0;
              v_d     = '0;
              state_d = ST_RD;
            end
            OP_NOTE: begin
              if (32'(voice_select_i) < 32'(MUSIC_VOICES) &&
                  instrument_select_i < 3'(NUM_INSTR)) begin
                ctl_we       = 1'b1;
                ctl_wa       = AW'(voice_select_i);
                ctl_wd.step  = NoteStep[(note_index_i > 6'd36) ? 6'd36 : note_index_i];
                ctl_wd.level = 17'd0;
                ctl_wd.stage = STG_ATK;
                ctl_wd.instr = instrument_select_i;
              end
            end
            OP_FX: begin
              if (effect_select_i != 3'd0 && effect_select_i != 3'd7) begin
                ctl_we       = 1'b1;
                ctl_wa       = FxAddr;
                ctl_wd.step  = FxStep[effect_select_i];
                ctl_wd.level = LVL_FULL;
                ctl_wd.stage = STG_REL;
                ctl_wd.instr = FX_INSTR[effect_select_i];
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD:  state_d = ST_ENV;
      ST_ENV: state_d = ST_OSC;
      ST_OSC: begin
        ctl_we       = 1'b1;
        ctl_wd.step  = cur_ctl_q.step;
        ctl_wd.level = nl;
        ctl_wd.stage = ns;
        ctl_wd.instr = cur_ctl_q.instr;
        // An idle voice keeps its phases untouched.
        phs_we       = !n_idle;
        phs_wd.osc   = osc_n;
        phs_wd.vib   = (ins_cur.vdepth != 5'd0) ? vib_n : cur_phs_q.vib;
        state_d      = ST_WAV;
      end
      ST_WAV: begin
        if (!idle_q && ins_cur.wave == WV_NOISE) begin
          lfsr_d = wave_lfsr;
        end
        state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: state_d = ST_ACC;
      ST_ACC: begin
        acc_d = acc_q + 20'(sv >>> 2);
        v_d   = v_q + 1'b1;
        if (v_q == FxAddr) begin
          v_d     = v_q;
          state_d = ST_WND;
        end else if (v_q == LastMus) begin
          state_d = ST_GAIN;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_GAIN: state_d = ST_GSC;
      ST_GSC: begin
        acc_d   = 20'(gprod_q >>> 16);
        state_d = ST_RD;
      end
      ST_WND: begin
        lfsr_d  = wl;
        wind_d  = wind_q + 17'(wdiff >>> 6);
        state_d = ST_WMUL;
      end
      ST_WMUL: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      v_q         <= '0;
      tension_q   <= '0;
      lfsr_q      <= LFSR_SEED;
      wind_q      <= '0;
      gain_q      <= GAIN_FULL;
      acc_q       <= '0;
      vld_ctl_q   <= '0;
      vld_phs_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v_q     <= v_d;
      lfsr_q  <= lfsr_d;
      wind_q  <= wind_d;
      gain_q  <= gain_d;
      acc_q   <= acc_d;
      if (cfg_wr && !paddr[2]) begin
        tension_q <= pwdata[7:0];
      end
      if (ctl_we) begin
        vld_ctl_q[ctl_wa] <= 1'b1;
      end
      if (phs_we) begin
        vld_phs_q[v_q] <= 1'b1;
      end
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ctl_q  <= mem_ctl[v_q];
    rd_phs_q  <= mem_phs[v_q];
    rdv_ctl_q <= vld_ctl_q[v_q];
    rdv_phs_q <= vld_phs_q[v_q];
    if (ctl_we) begin
      mem_ctl[ctl_wa] <= ctl_wd;
    end
    if (phs_we) begin
      mem_phs[v_q] <= phs_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ENV) begin
      cur_ctl_q  <= ctl_rd;
      cur_phs_q  <= phs_rd;
      prod_q     <= env_prod;
      lvl1_q     <= env_lvl1;
      stg1_q     <= env_stg1;
      use_prod_q <= env_use;
    end
    if (state_q == ST_OSC) begin
      osc_q  <= osc_n;
      lvl_q  <= nl;
      idle_q <= n_idle;
    end
    if (state_q == ST_WAV) begin
      sprod_q <= idle_q ? 34'sd0 : sp;
    end
    if (state_q == ST_MUL) begin
      y_q <= yf[25:0];
    end
    if (state_q == ST_DIV) begin
      a_q   <= a_n;
      neg_q <= y_q < 0;
      qe_q  <= est[38:23];
    end
    if (state_q == ST_GAIN) begin
      gprod_q <= gp;
    end
    if (state_q == ST_WMUL) begin
      wprod_q <= wp;
    end
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      if (tot > 23'sd32767) begin
        sample_q <= 16'sh7FFF;
      end else if (tot < -23'sd32768) begin
        sample_q <= 16'sh8000;
      end else begin
        sample_q <= tot[15:0];
      end
    end
  end

endmodule

// ===== rtl/mves_checker.sv =====
// ----------------------------------------------------------------------------
// mves_checker
// Port-level assertions for the envelope synthesizer, bound to the top level.
// ----------------------------------------------------------------------------
module mves_checker import mves_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [2:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         op_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] sample_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(sample_o))
    else $error("sample changed while stalled");

  // A tick keeps the sequencer busy, so input is not ready right after it.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i == OP_TICK |=> !in_ready_o)
    else $error("input ready right after a tick transfer");

  a_cfg_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && !paddr[2]
    |=> (paddr[2] || prdata == {24'd0, $past(pwdata[7:0])}))
    else $error("tension register does not read back");

endmodule

bind multi_voice_envelope_synth mves_checker u_mves_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the envelope synthesizer against a behavioral predictor. Note-on,
// effect and tick transfers with random gaps and output stalls are sent, the
// tension register is changed between phases, and every sample is compared.
// ----------------------------------------------------------------------------
module tb_top;
  import mves_pkg::*;

  localparam int NV = MUSIC_VOICES_DEF + 1;
  localparam int FXV = MUSIC_VOICES_DEF;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] vsel;
    logic [5:0] note;
    logic [2:0] ins;
    logic [2:0] fx;
    logic       duck;
  } synth_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = '0, voice_select_i = '0;
  logic [5:0] note_index_i = '0;
  logic [2:0] instrument_select_i = '0, effect_select_i = '0;
  logic duck_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] sample_o;

  multi_voice_envelope_synth i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [31:0] p_step [NV];
  logic [31:0] p_osc [NV];
  logic [31:0] p_vib [NV];
  longint      p_lvl [NV];
  logic [1:0]  p_stage [NV];
  logic [2:0]  p_instr [NV];
  logic [15:0] p_lfsr;
  longint      p_wind, p_gain;
  logic [7:0]  p_tension;

  synth_item_t pending_items [$];
  logic signed [15:0] expected_samples [$];
  int errors = 0, samples_seen = 0, items_sent = 0;
  int in_gap = 0, out_gap = 0;
  longint cycles = 0;
  bit stall_free = 0;

  typedef struct {
    int wave, duty, atk, dec, sus, rel, vdepth, vrate, vol;
  } voice_patch_t;

  function automatic voice_patch_t patch_of(input logic [2:0] idx);
    voice_patch_t p;
    case (idx % 6)
      1: p = '{WV_PULSE, 96, 1800, 65450, 20000, 65200, 12, 40, 170};
      2: p = '{WV_TRIANGLE, 128, 240, 65530, 30000, 65400, 5, 18, 130};
      3: p = '{WV_NOISE, 128, 20000, 64200, 0, 64000, 0, 0, 210};
      4: p = '{WV_PULSE, 64, 6000, 65200, 8000, 65000, 20, 55, 150};
      5: p = '{WV_TRIANGLE, 128, 4000, 65350, 12000, 65250, 8, 28, 160};
      default: p = '{WV_RAMP, 128, 900, 65500, 26000, 65100, 0, 0, 200};
    endcase
    return p;
  endfunction

  // Arithmetic shift right rounds toward minus infinity, as >>> does on longint.
  function automatic longint asr(input longint x, input int k);
    return x >>> k;
  endfunction

  function automatic logic [31:0] pitch_step(input int dhz);
    logic [63:0] num;
    num = longint'(dhz) << 32;
    return 32'(num / 64'(SAMPLE_RATE_DEF * 10));
  endfunction

  function automatic longint next_noise();
    p_lfsr = (p_lfsr >> 1) ^ (p_lfsr[0] ? 16'hB400 : 16'h0000);
    return longint'(p_lfsr) - 32768;
  endfunction

  function automatic longint wave_value(input int wave, input logic [31:0] ph,
                                        input int duty);
    longint t;
    if (wave == WV_RAMP) return longint'(ph >> 16) - 32768;
    if (wave == WV_TRIANGLE) begin
      t = longint'((ph >> 15) & 32'h1FFFF);
      return (t < 65536 ? t : 131071 - t) - 32768;
    end
    if (wave == WV_NOISE) return next_noise();
    if (longint'(ph) < (longint'(duty) << 24)) return 32767 - duty * 128;
    return -duty * 128;
  endfunction

  function automatic void advance_envelope(input int v);
    voice_patch_t p;
    p = patch_of(p_instr[v]);
    case (p_stage[v])
      STG_ATK: begin
        p_lvl[v] += p.atk;
        if (p_lvl[v] >= 65536) begin
          p_lvl[v] = 65536;
          p_stage[v] = STG_DEC;
        end
      end
      STG_DEC: begin
        if (p_lvl[v] > p.sus) begin
          p_lvl[v] = asr(p_lvl[v] * p.dec, 16);
          if (p_lvl[v] < p.sus) p_lvl[v] = p.sus;
        end
      end
      STG_REL: begin
        p_lvl[v] = asr(p_lvl[v] * p.rel, 16);
        if (p_lvl[v] < 64) begin
          p_lvl[v] = 0;
          p_stage[v] = STG_IDLE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic longint render_voice(input int v);
    voice_patch_t p;
    logic [31:0] inc;
    longint t, s;
    p = patch_of(p_instr[v]);
    inc = p_step[v];
    if (p_stage[v] == STG_IDLE && p_lvl[v] <= 0) return 0;
    if (p.vdepth != 0) begin
      p_vib[v] += 32'(p.vrate) << 18;
      t = wave_value(WV_TRIANGLE, p_vib[v], 128);
      inc += 32'((t / 256) * p.vdepth / 64);
    end
    p_osc[v] += inc;
    s = wave_value(p.wave, p_osc[v], p.duty);
    s = asr(s * p_lvl[v], 16);
    return s * p.vol / 255;
  endfunction

  // Applies one item to the predictor; ticks push the expected sample.
  function automatic void predict_synth(input synth_item_t it);
    longint want, mix, n;
    logic [5:0] nt;
    case (it.op)
      OP_NOTE: begin
        if (it.ins < NUM_INSTR) begin
          nt = it.note >= NUM_NOTES ? 6'(NUM_NOTES - 1) : it.note;
          p_instr[it.vsel] = it.ins;
          p_step[it.vsel] = pitch_step(PITCH_DHZ[nt]);
          p_lvl[it.vsel] = 0;
          p_stage[it.vsel] = STG_ATK;
        end
      end
      OP_FX: begin
        if (it.fx >= 1 && it.fx <= 6) begin
          p_step[FXV] = pitch_step(FX_DHZ[it.fx]);
          p_lvl[FXV] = 65536;
          p_stage[FXV] = STG_REL;
          p_instr[FXV] = FX_INSTR[it.fx];
        end
      end
      OP_TICK: begin
        want = it.duck ? (12 << 12) : 65536;
        mix = 0;
        if (p_gain < want) begin
          p_gain += 48;
          if (p_gain > want) p_gain = want;
        end
        if (p_gain > want) begin
          p_gain -= 48;
          if (p_gain < want) p_gain = want;
        end
        for (int v = 0; v < FXV; v++) begin
          advance_envelope(v);
          mix += asr(render_voice(v), 2);
        end
        mix = asr(mix * p_gain, 16);
        advance_envelope(FXV);
        mix += asr(render_voice(FXV), 2);
        n = next_noise();
        p_wind += asr(n - p_wind, 6);
        mix += asr(asr(p_wind * (32768 + (longint'(p_tension) << 6)), 16), 3);
        mix *= 2;
        if (mix > 32767) mix = 32767;
        if (mix < -32768) mix = -32768;
        expected_samples.push_back(16'(mix));
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3);
    return $urandom_range(60, 20);
  endfunction

  // Driver: presents queued items, predicts each one on its transfer.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_synth(pending_items.pop_front());
        items_sent <= items_sent + 1;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > (in_valid_i && in_ready_o ? 0 : 0)) begin
          in_valid_i <= 1'b1;
          {op_i, voice_select_i, note_index_i, instrument_select_i, effect_select_i,
           duck_i} <= pending_items[0];
          in_gap <= stall_free ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string msg);
    $display("sample %0d: %s", samples_seen, msg);
    errors++;
  endtask

  // Monitor: random back-pressure and the sample check.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d", sample_o));
        end else begin
          if (sample_o !== expected_samples[0])
            report_mismatch($sformatf("got %0d expected %0d", sample_o,
                                      expected_samples[0]));
          void'(expected_samples.pop_front());
        end
        samples_seen <= samples_seen + 1;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!stall_free && $urandom_range(3) == 0) out_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_tension(input logic [7:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    p_tension = val;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_samples.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic synth_item_t mk(input logic [1:0] op, input logic [1:0] vs,
                                     input logic [5:0] nt, input logic [2:0] ins,
                                     input logic [2:0] fx, input logic dk);
    return '{op, vs, nt, ins, fx, dk};
  endfunction

  function automatic synth_item_t random_item();
    synth_item_t it;
    int r;
    it = synth_item_t'($urandom);
    r = $urandom_range(99);
    if (r < 70) it.op = OP_TICK;
    else if (r < 85) begin
      it.op = OP_NOTE;
      if ($urandom_range(9) != 0) it.ins = 3'($urandom_range(5));
    end else if (r < 96) it.op = OP_FX;
    else it.op = OP_RSVD;
    // Long duck runs let the gain slew reach both ends.
    it.duck = (cycles / 20000) % 2 == 0 ? ($urandom_range(9) == 0) : ($urandom_range(9) != 0);
    return it;
  endfunction

  initial begin
    for (int v = 0; v < NV; v++) begin
      p_step[v] = 0; p_osc[v] = 0; p_vib[v] = 0;
      p_lvl[v] = 0; p_stage[v] = STG_IDLE; p_instr[v] = 0;
    end
    p_lfsr = LFSR_SEED;
    p_wind = 0;
    p_gain = 65536;
    p_tension = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every instrument, note extremes, all effects, odd codes.
    for (int i = 0; i < 6; i++)
      pending_items.push_back(mk(OP_NOTE, 2'(i), i == 0 ? 6'd0 : 6'(i * 12), 3'(i),
                                 3'd0, 1'b0));
    pending_items.push_back(mk(OP_NOTE, 2'd3, 6'd63, 3'd6, 3'd7, 1'b1));
    pending_items.push_back(mk(OP_NOTE, 2'd2, 6'd37, 3'd7, 3'd0, 1'b0));
    for (int f = 0; f < 8; f++) begin
      pending_items.push_back(mk(OP_FX, 2'd0, 6'd0, 3'd0, 3'(f), 1'b0));
      pending_items.push_back(mk(OP_TICK, 2'd0, 6'd0, 3'd0, 3'd0, 1'(f & 1)));
    end
    pending_items.push_back(mk(OP_RSVD, 2'd3, 6'd63, 3'd7, 3'd7, 1'b1));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_tension(ph == 0 ? 8'd255 : ph == 3 ? 8'd0 : 8'($urandom));
      stall_free = (ph == 2);
      for (int k = 0; k < 160; k++) pending_items.push_back(random_item());
      drain();
    end

    $display("covered %0d transfers, %0d samples, four tension settings",
             items_sent, samples_seen);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
